@@ sv/triangle_walkability_classifier_unit_macros.svh @@
// Assertion macros for the triangle walkability classifier checker.
`ifndef TRIANGLE_WALKABILITY_CLASSIFIER_UNIT_MACROS_SVH
`define TRIANGLE_WALKABILITY_CLASSIFIER_UNIT_MACROS_SVH

// Checked only outside reset.
`define TWC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define TWC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/twc_pkg.sv @@
// Shared widths, constants and stage types of the triangle walkability classifier.
`default_nettype none

package twc_pkg;

  localparam int COORD_BITS = 24;
  localparam int COS_W      = 16;
  localparam int FLOOR_W    = 24;
  localparam int CFG_W      = 24;
  localparam int IDX_W      = 1;

  localparam logic [IDX_W-1:0] REG_COS   = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_FLOOR = IDX_W'(1);

  localparam logic signed [COS_W-1:0]   COS_RESET   = 16'sd23170;
  localparam logic signed [FLOOR_W-1:0] FLOOR_RESET = -24'sd256000;

  // edge, cross product and magnitude widths
  localparam int EDGE_W = COORD_BITS + 1;
  localparam int PROD_W = 2 * EDGE_W;
  localparam int NORM_W = PROD_W + 1;
  localparam int MAG_W  = PROD_W;
  localparam int HALF_W = MAG_W / 2;
  localparam int SQ_W   = 2 * MAG_W;

  // scaling by the squared cosine terms, split into chunks
  localparam int NCH    = 4;
  localparam int CH_W   = SQ_W / NCH;
  localparam int CSQ_W  = 2 * COS_W - 1;
  localparam int PP_W   = CH_W + CSQ_W;
  localparam int PAIR_W = PP_W + CH_W + 1;
  localparam int SC_W   = SQ_W + CSQ_W;

  // height test width
  localparam int LOW_W = ((COORD_BITS > FLOOR_W) ? COORD_BITS : FLOOR_W) + 2;

  // 1.0 squared in Q1.30
  localparam logic [CSQ_W-1:0] COS_ONE_SQ = CSQ_W'(1) << (2 * COS_W - 2);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [EDGE_W-1:0]     edge_t;

  typedef struct packed {
    coord_t ax;
    coord_t ay;
    coord_t az;
    coord_t bx;
    coord_t by;
    coord_t bz;
    coord_t cx;
    coord_t cy;
    coord_t cz;
  } vtx_t;

  typedef struct packed {
    logic walkable;
    logic too_steep;
    logic too_low;
  } cls_t;

  typedef struct packed {
    edge_t            e1x;
    edge_t            e1y;
    edge_t            e1z;
    edge_t            e2x;
    edge_t            e2y;
    edge_t            e2z;
    logic             too_low;
    logic             c_pos;
    logic             c_neg;
    logic [CSQ_W-1:0] csq;
  } front_t;

  typedef struct packed {
    logic too_low;
    logic decided;
    logic steep_fix;
    logic ny_neg;
  } flag_t;

  typedef struct packed {
    logic [MAG_W-1:0] mx;
    logic [MAG_W-1:0] my;
    logic [MAG_W-1:0] mz;
    flag_t            flag;
    logic [CSQ_W-1:0] csq;
    logic [CSQ_W-1:0] kc;
  } norm_t;

  typedef struct packed {
    logic [SQ_W-1:0]  sy;
    logic [SQ_W-1:0]  sxz;
    flag_t            flag;
    logic [CSQ_W-1:0] csq;
    logic [CSQ_W-1:0] kc;
  } sq_t;

endpackage

`default_nettype wire

@@ sv/twc_front.sv @@
// Front stage: edge vectors, height test and squared cosine limit.
`default_nettype none

module twc_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               vtx_valid,
  output logic                               vtx_stall,
  input  twc_pkg::vtx_t                      vtx,
  input  logic signed [twc_pkg::COS_W-1:0]   cos_max_slope,
  input  logic signed [twc_pkg::FLOOR_W-1:0] min_height,
  output logic                               front_valid,
  input  logic                               front_stall,
  output twc_pkg::front_t                    front
);
  import twc_pkg::*;

  logic                      en;
  logic signed [2*COS_W-1:0] c_prod;
  logic signed [LOW_W-1:0]   ysum;
  logic signed [LOW_W-1:0]   floor3;
  front_t                    front_next;

  assign en        = !front_valid || !front_stall;
  assign vtx_stall = !en;

  assign c_prod = cos_max_slope * cos_max_slope;
  assign ysum   = LOW_W'(vtx.ay) + LOW_W'(vtx.by) + LOW_W'(vtx.cy);
  assign floor3 = LOW_W'(min_height) + (LOW_W'(min_height) <<< 1);

  always_comb begin
    front_next         = '0;
    front_next.e1x     = EDGE_W'(vtx.bx) - EDGE_W'(vtx.ax);
    front_next.e1y     = EDGE_W'(vtx.by) - EDGE_W'(vtx.ay);
    front_next.e1z     = EDGE_W'(vtx.bz) - EDGE_W'(vtx.az);
    front_next.e2x     = EDGE_W'(vtx.cx) - EDGE_W'(vtx.ax);
    front_next.e2y     = EDGE_W'(vtx.cy) - EDGE_W'(vtx.ay);
    front_next.e2z     = EDGE_W'(vtx.cz) - EDGE_W'(vtx.az);
    front_next.too_low = ysum < floor3;
    front_next.c_pos   = !cos_max_slope[COS_W-1] && (cos_max_slope != '0);
    front_next.c_neg   = cos_max_slope[COS_W-1];
    front_next.csq     = c_prod[CSQ_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else if (en) begin
      front_valid <= vtx_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      front <= front_next;
    end
  end

endmodule

`default_nettype wire

@@ sv/twc_normal.sv @@
// Normal stages: cross product terms, normal components, magnitudes and sign cases.
`default_nettype none

module twc_normal (
  input  logic            clk,
  input  logic            rst,
  input  logic            front_valid,
  output logic            front_stall,
  input  twc_pkg::front_t front,
  output logic            norm_valid,
  input  logic            norm_stall,
  output twc_pkg::norm_t  norm
);
  import twc_pkg::*;

  typedef struct packed {
    logic signed [PROD_W-1:0] p0;
    logic signed [PROD_W-1:0] p1;
    logic signed [PROD_W-1:0] p2;
    logic signed [PROD_W-1:0] p3;
    logic signed [PROD_W-1:0] p4;
    logic signed [PROD_W-1:0] p5;
    logic                     too_low;
    logic                     c_pos;
    logic                     c_neg;
    logic [CSQ_W-1:0]         csq;
    logic [CSQ_W-1:0]         kc;
  } prod_t;

  typedef struct packed {
    logic signed [NORM_W-1:0] nx;
    logic signed [NORM_W-1:0] ny;
    logic signed [NORM_W-1:0] nz;
    logic                     too_low;
    logic                     c_pos;
    logic                     c_neg;
    logic [CSQ_W-1:0]         csq;
    logic [CSQ_W-1:0]         kc;
  } cross_t;

  function automatic logic [MAG_W-1:0] mag(input logic signed [NORM_W-1:0] v);
    logic signed [NORM_W-1:0] t;
    t = v[NORM_W-1] ? -v : v;
    return t[MAG_W-1:0];
  endfunction

  prod_t  prod;
  prod_t  prod_next;
  cross_t nvec;
  cross_t cross_next;
  norm_t  norm_next;
  logic   prod_valid;
  logic   cross_valid;
  logic   prod_en;
  logic   cross_en;
  logic   norm_en;
  logic   zero;
  logic   ny_neg;

  assign norm_en     = !norm_valid || !norm_stall;
  assign cross_en    = !cross_valid || norm_en;
  assign prod_en     = !prod_valid || cross_en;
  assign front_stall = !prod_en;

  always_comb begin
    prod_next         = '0;
    prod_next.p0      = front.e1y * front.e2z;
    prod_next.p1      = front.e1z * front.e2y;
    prod_next.p2      = front.e1z * front.e2x;
    prod_next.p3      = front.e1x * front.e2z;
    prod_next.p4      = front.e1x * front.e2y;
    prod_next.p5      = front.e1y * front.e2x;
    prod_next.too_low = front.too_low;
    prod_next.c_pos   = front.c_pos;
    prod_next.c_neg   = front.c_neg;
    prod_next.csq     = front.csq;
    prod_next.kc      = COS_ONE_SQ - front.csq;
  end

  always_comb begin
    cross_next         = '0;
    cross_next.nx      = NORM_W'(prod.p0) - NORM_W'(prod.p1);
    cross_next.ny      = NORM_W'(prod.p2) - NORM_W'(prod.p3);
    cross_next.nz      = NORM_W'(prod.p4) - NORM_W'(prod.p5);
    cross_next.too_low = prod.too_low;
    cross_next.c_pos   = prod.c_pos;
    cross_next.c_neg   = prod.c_neg;
    cross_next.csq     = prod.csq;
    cross_next.kc      = prod.kc;
  end

  // zero normal: 90 degrees; otherwise the sign cases settle all but the squared compare
  assign zero   = (nvec.nx == '0) && (nvec.ny == '0) && (nvec.nz == '0);
  assign ny_neg = nvec.ny[NORM_W-1];

  always_comb begin
    norm_next                = '0;
    norm_next.mx             = mag(nvec.nx);
    norm_next.my             = mag(nvec.ny);
    norm_next.mz             = mag(nvec.nz);
    norm_next.flag.too_low   = nvec.too_low;
    norm_next.flag.decided   = zero || (ny_neg && !nvec.c_neg) || (!ny_neg && !nvec.c_pos);
    norm_next.flag.steep_fix = zero ? nvec.c_pos : ny_neg;
    norm_next.flag.ny_neg    = ny_neg;
    norm_next.csq            = nvec.csq;
    norm_next.kc             = nvec.kc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid  <= 1'b0;
      cross_valid <= 1'b0;
      norm_valid  <= 1'b0;
    end else begin
      if (prod_en) begin
        prod_valid <= front_valid;
      end
      if (cross_en) begin
        cross_valid <= prod_valid;
      end
      if (norm_en) begin
        norm_valid <= cross_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (prod_en) begin
      prod <= prod_next;
    end
    if (cross_en) begin
      nvec <= cross_next;
    end
    if (norm_en) begin
      norm <= norm_next;
    end
  end

endmodule

`default_nettype wire

@@ sv/twc_square.sv @@
// Square stages: half-word partial products, squared components, horizontal sum.
`default_nettype none

module twc_square (
  input  logic           clk,
  input  logic           rst,
  input  logic           norm_valid,
  output logic           norm_stall,
  input  twc_pkg::norm_t norm,
  output logic           sq_valid,
  input  logic           sq_stall,
  output twc_pkg::sq_t   sq
);
  import twc_pkg::*;

  typedef struct packed {
    logic [2*HALF_W-1:0] hh;
    logic [2*HALF_W-1:0] hl;
    logic [2*HALF_W-1:0] ll;
  } part_t;

  typedef struct packed {
    part_t            px;
    part_t            py;
    part_t            pz;
    flag_t            flag;
    logic [CSQ_W-1:0] csq;
    logic [CSQ_W-1:0] kc;
  } parts_t;

  typedef struct packed {
    logic [SQ_W-1:0]  sqx;
    logic [SQ_W-1:0]  sqy;
    logic [SQ_W-1:0]  sqz;
    flag_t            flag;
    logic [CSQ_W-1:0] csq;
    logic [CSQ_W-1:0] kc;
  } sqr_t;

  function automatic part_t split(input logic [MAG_W-1:0] m);
    part_t r;
    r.hh = m[MAG_W-1:HALF_W] * m[MAG_W-1:HALF_W];
    r.hl = m[MAG_W-1:HALF_W] * m[HALF_W-1:0];
    r.ll = m[HALF_W-1:0] * m[HALF_W-1:0];
    return r;
  endfunction

  function automatic logic [SQ_W-1:0] square(input part_t p);
    return (SQ_W'(p.hh) << (2 * HALF_W)) + (SQ_W'(p.hl) << (HALF_W + 1)) + SQ_W'(p.ll);
  endfunction

  parts_t part;
  parts_t part_next;
  sqr_t   sqr;
  sqr_t   sqr_next;
  sq_t    sq_next;
  logic   part_valid;
  logic   sqr_valid;
  logic   part_en;
  logic   sqr_en;
  logic   sq_en;

  assign sq_en      = !sq_valid || !sq_stall;
  assign sqr_en     = !sqr_valid || sq_en;
  assign part_en    = !part_valid || sqr_en;
  assign norm_stall = !part_en;

  always_comb begin
    part_next      = '0;
    part_next.px   = split(norm.mx);
    part_next.py   = split(norm.my);
    part_next.pz   = split(norm.mz);
    part_next.flag = norm.flag;
    part_next.csq  = norm.csq;
    part_next.kc   = norm.kc;
  end

  always_comb begin
    sqr_next      = '0;
    sqr_next.sqx  = square(part.px);
    sqr_next.sqy  = square(part.py);
    sqr_next.sqz  = square(part.pz);
    sqr_next.flag = part.flag;
    sqr_next.csq  = part.csq;
    sqr_next.kc   = part.kc;
  end

  always_comb begin
    sq_next      = '0;
    sq_next.sy   = sqr.sqy;
    sq_next.sxz  = sqr.sqx + sqr.sqz;
    sq_next.flag = sqr.flag;
    sq_next.csq  = sqr.csq;
    sq_next.kc   = sqr.kc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      part_valid <= 1'b0;
      sqr_valid  <= 1'b0;
      sq_valid   <= 1'b0;
    end else begin
      if (part_en) begin
        part_valid <= norm_valid;
      end
      if (sqr_en) begin
        sqr_valid <= part_valid;
      end
      if (sq_en) begin
        sq_valid <= sqr_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (part_en) begin
      part <= part_next;
    end
    if (sqr_en) begin
      sqr <= sqr_next;
    end
    if (sq_en) begin
      sq <= sq_next;
    end
  end

endmodule

`default_nettype wire

@@ sv/twc_scale.sv @@
// Scale stages: chunked products by the cosine terms, partial sums, final compare.
`default_nettype none

module twc_scale (
  input  logic          clk,
  input  logic          rst,
  input  logic          sq_valid,
  output logic          sq_stall,
  input  twc_pkg::sq_t  sq,
  output logic          cls_valid,
  input  logic          cls_stall,
  output twc_pkg::cls_t cls
);
  import twc_pkg::*;

  typedef struct packed {
    logic [NCH-1:0][PP_W-1:0] lpp;
    logic [NCH-1:0][PP_W-1:0] rpp;
    flag_t                    flag;
  } pp_t;

  typedef struct packed {
    logic [PAIR_W-1:0] la;
    logic [PAIR_W-1:0] lb;
    logic [PAIR_W-1:0] ra;
    logic [PAIR_W-1:0] rb;
    flag_t             flag;
  } pair_t;

  typedef struct packed {
    logic [SC_W-1:0] lhs;
    logic [SC_W-1:0] rhs;
    flag_t           flag;
  } tot_t;

  pp_t   pp;
  pp_t   pp_next;
  pair_t pair;
  pair_t pair_next;
  tot_t  tot;
  tot_t  tot_next;
  cls_t  cls_next;
  logic  pp_valid;
  logic  pair_valid;
  logic  tot_valid;
  logic  pp_en;
  logic  pair_en;
  logic  tot_en;
  logic  cls_en;
  logic  steep;

  assign cls_en   = !cls_valid || !cls_stall;
  assign tot_en   = !tot_valid || cls_en;
  assign pair_en  = !pair_valid || tot_en;
  assign pp_en    = !pp_valid || pair_en;
  assign sq_stall = !pp_en;

  // lhs = ny^2 * (1 - c^2), rhs = c^2 * (nx^2 + nz^2), both in Q.30 of the limit
  always_comb begin
    pp_next      = '0;
    pp_next.flag = sq.flag;
    for (int k = 0; k < NCH; k++) begin
      pp_next.lpp[k] = sq.sy[k*CH_W +: CH_W] * sq.kc;
      pp_next.rpp[k] = sq.sxz[k*CH_W +: CH_W] * sq.csq;
    end
  end

  always_comb begin
    pair_next      = '0;
    pair_next.la   = PAIR_W'(pp.lpp[0]) + (PAIR_W'(pp.lpp[1]) << CH_W);
    pair_next.lb   = PAIR_W'(pp.lpp[2]) + (PAIR_W'(pp.lpp[3]) << CH_W);
    pair_next.ra   = PAIR_W'(pp.rpp[0]) + (PAIR_W'(pp.rpp[1]) << CH_W);
    pair_next.rb   = PAIR_W'(pp.rpp[2]) + (PAIR_W'(pp.rpp[3]) << CH_W);
    pair_next.flag = pp.flag;
  end

  always_comb begin
    tot_next      = '0;
    tot_next.lhs  = SC_W'(pair.la) + (SC_W'(pair.lb) << (2 * CH_W));
    tot_next.rhs  = SC_W'(pair.ra) + (SC_W'(pair.rb) << (2 * CH_W));
    tot_next.flag = pair.flag;
  end

  // downward normal with a negative limit flips the direction of the compare
  assign steep = tot.flag.decided ? tot.flag.steep_fix :
                 tot.flag.ny_neg  ? (tot.rhs < tot.lhs) : (tot.lhs < tot.rhs);

  always_comb begin
    cls_next           = '0;
    cls_next.too_steep = steep;
    cls_next.too_low   = tot.flag.too_low;
    cls_next.walkable  = !steep && !tot.flag.too_low;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pp_valid   <= 1'b0;
      pair_valid <= 1'b0;
      tot_valid  <= 1'b0;
      cls_valid  <= 1'b0;
    end else begin
      if (pp_en) begin
        pp_valid <= sq_valid;
      end
      if (pair_en) begin
        pair_valid <= pp_valid;
      end
      if (tot_en) begin
        tot_valid <= pair_valid;
      end
      if (cls_en) begin
        cls_valid <= tot_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pp_en) begin
      pp <= pp_next;
    end
    if (pair_en) begin
      pair <= pair_next;
    end
    if (tot_en) begin
      tot <= tot_next;
    end
    if (cls_en) begin
      cls <= cls_next;
    end
  end

endmodule

`default_nettype wire

@@ sv/triangle_walkability_classifier_unit.sv @@
// Top level of the triangle walkability classifier: config registers and pipeline.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-----------------------------------
//   vtx      | vtx_valid/vtx_stall  | vtx_t: three vertices, Q16.8
//   cls      | cls_valid/cls_stall  | cls_t: walkable, too_steep, too_low
//   config   | wr_en                | wr_index, wr_data
//
// One request per cycle sustained while cls_stall is low; a result passes through the register
// stages front 1, normal 3, square 3 and scale 4 (front loads at the accept edge).
// Reset clears every stage valid bit and loads the default limits.
// Each stage holds while the one after it is full and stalled; empty stages
// keep taking data, so bubbles close up behind a stalled result.
`default_nettype none

module triangle_walkability_classifier_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        vtx_valid,
  output logic                        vtx_stall,
  input  twc_pkg::vtx_t               vtx,
  output logic                        cls_valid,
  input  logic                        cls_stall,
  output twc_pkg::cls_t               cls,
  input  logic                        wr_en,
  input  logic [twc_pkg::IDX_W-1:0]   wr_index,
  input  logic [twc_pkg::CFG_W-1:0]   wr_data
);
  import twc_pkg::*;

  logic signed [COS_W-1:0]   cos_max_slope;
  logic signed [FLOOR_W-1:0] min_height;

  logic   front_valid;
  logic   front_stall;
  front_t front;
  logic   norm_valid;
  logic   norm_stall;
  norm_t  norm;
  logic   sq_valid;
  logic   sq_stall;
  sq_t    sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      cos_max_slope <= COS_RESET;
      min_height    <= FLOOR_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_COS:   cos_max_slope <= wr_data[COS_W-1:0];
        REG_FLOOR: min_height    <= wr_data[FLOOR_W-1:0];
      endcase
    end
  end

  twc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .vtx_valid     (vtx_valid),
    .vtx_stall     (vtx_stall),
    .vtx           (vtx),
    .cos_max_slope (cos_max_slope),
    .min_height    (min_height),
    .front_valid   (front_valid),
    .front_stall   (front_stall),
    .front         (front)
  );

  twc_normal u_normal (
    .clk         (clk),
    .rst         (rst),
    .front_valid (front_valid),
    .front_stall (front_stall),
    .front       (front),
    .norm_valid  (norm_valid),
    .norm_stall  (norm_stall),
    .norm        (norm)
  );

  twc_square u_square (
    .clk        (clk),
    .rst        (rst),
    .norm_valid (norm_valid),
    .norm_stall (norm_stall),
    .norm       (norm),
    .sq_valid   (sq_valid),
    .sq_stall   (sq_stall),
    .sq         (sq)
  );

  twc_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .sq_valid  (sq_valid),
    .sq_stall  (sq_stall),
    .sq        (sq),
    .cls_valid (cls_valid),
    .cls_stall (cls_stall),
    .cls       (cls)
  );

endmodule

`default_nettype wire

@@ sv/twc_checker.sv @@
// Port-level checker for the triangle walkability classifier, bound to the top level.
`default_nettype none

`include "triangle_walkability_classifier_unit_macros.svh"

module twc_checker (
  input logic          clk,
  input logic          rst,
  input logic          vtx_valid,
  input logic          vtx_stall,
  input logic          cls_valid,
  input logic          cls_stall,
  input twc_pkg::cls_t cls
);

  `TWC_ASSERT(a_flags_agree, clk, rst, cls_valid |-> (cls.walkable == (!cls.too_steep && !cls.too_low)), "walkable disagrees with the flags")

  `TWC_ASSERT(a_result_holds, clk, rst, cls_valid && cls_stall |=> cls_valid && $stable(cls), "stalled result changed")

  `TWC_ASSERT_ALWAYS(a_reset_empties, clk, rst |=> !cls_valid, "result valid after reset")

  `TWC_ASSERT(a_no_stall_when_empty, clk, rst, !cls_valid |-> !vtx_stall || !vtx_valid && vtx_stall && cls_valid, "input stalled with no result waiting")

endmodule

bind triangle_walkability_classifier_unit twc_checker u_twc_checker (
  .clk       (clk),
  .rst       (rst),
  .vtx_valid (vtx_valid),
  .vtx_stall (vtx_stall),
  .cls_valid (cls_valid),
  .cls_stall (cls_stall),
  .cls       (cls)
);

`default_nettype wire
